>>> design/apl_pkg.sv
package apl_pkg;

  // Most results that one input beat can cause
  localparam int unsigned MaxResults = 3;

  // Token kinds
  localparam logic [3:0] KindLbrace   = 4'd0;
  localparam logic [3:0] KindRbrace   = 4'd1;
  localparam logic [3:0] KindLparen   = 4'd2;
  localparam logic [3:0] KindRparen   = 4'd3;
  localparam logic [3:0] KindEquals   = 4'd4;
  localparam logic [3:0] KindSemi     = 4'd5;
  localparam logic [3:0] KindComma    = 4'd6;
  localparam logic [3:0] KindWordByte = 4'd7;
  localparam logic [3:0] KindWordEnd  = 4'd8;
  localparam logic [3:0] KindEof      = 4'd9;
  localparam logic [3:0] KindError    = 4'd10;

  // Characters
  localparam logic [7:0] CharLbrace    = 8'h7B;
  localparam logic [7:0] CharRbrace    = 8'h7D;
  localparam logic [7:0] CharLparen    = 8'h28;
  localparam logic [7:0] CharRparen    = 8'h29;
  localparam logic [7:0] CharEquals    = 8'h3D;
  localparam logic [7:0] CharSemi      = 8'h3B;
  localparam logic [7:0] CharComma     = 8'h2C;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;
  localparam logic [7:0] CharSlash     = 8'h2F;
  localparam logic [7:0] CharStar      = 8'h2A;
  localparam logic [7:0] CharSpace     = 8'h20;
  localparam logic [7:0] CharLf        = 8'h0A;
  localparam logic [7:0] CharTab       = 8'h09;
  localparam logic [7:0] CharCr        = 8'h0D;
  localparam logic [7:0] CharN         = 8'h6E;
  localparam logic [7:0] CharT         = 8'h74;
  localparam logic [7:0] CharR         = 8'h72;

  // Lexer modes
  typedef enum logic [2:0] {
    ModeNormal,
    ModeSlash,
    ModeLine,
    ModeBlock,
    ModeStar,
    ModeQuote,
    ModeEsc
  } mode_e;

  typedef struct packed {
    mode_e mode;
    logic  word_open;
  } lex_state_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] word_char;
    logic       word_first;
    logic       run_last;
  } out_t;

endpackage

>>> design/apl_step.sv
module apl_step (
  input  apl_pkg::lex_state_t              state_i,
  input  apl_pkg::in_t                     in_i,
  output apl_pkg::lex_state_t              state_o,
  output apl_pkg::out_t [2:0]              res_o,
  output logic [1:0]                       count_o
);

  apl_pkg::mode_e      mode;
  logic                wo;
  logic [1:0]          n;
  apl_pkg::out_t [2:0] res;
  logic                do_norm;
  logic [7:0]          c;
  logic [7:0]          esc_c;
  logic                is_space;
  logic                is_punct;
  logic [3:0]          punct_kind;

  function automatic apl_pkg::out_t mk_res(logic [3:0] kind, logic [7:0] ch, logic first);
    apl_pkg::out_t r;
    r.token_kind = kind;
    r.word_char  = ch;
    r.word_first = first;
    r.run_last   = 1'b0;
    return r;
  endfunction

  assign c = in_i.text_byte;

  // Character classes
  always_comb begin
    is_space   = (c == apl_pkg::CharSpace) || (c inside {[8'd9:8'd13]});
    is_punct   = 1'b1;
    punct_kind = apl_pkg::KindLbrace;
    case (c)
      apl_pkg::CharLbrace: punct_kind = apl_pkg::KindLbrace;
      apl_pkg::CharRbrace: punct_kind = apl_pkg::KindRbrace;
      apl_pkg::CharLparen: punct_kind = apl_pkg::KindLparen;
      apl_pkg::CharRparen: punct_kind = apl_pkg::KindRparen;
      apl_pkg::CharEquals: punct_kind = apl_pkg::KindEquals;
      apl_pkg::CharSemi:   punct_kind = apl_pkg::KindSemi;
      apl_pkg::CharComma:  punct_kind = apl_pkg::KindComma;
      default:             is_punct   = 1'b0;
    endcase
  end

  // Escape decode inside quotes
  always_comb begin
    case (c)
      apl_pkg::CharN: esc_c = apl_pkg::CharLf;
      apl_pkg::CharT: esc_c = apl_pkg::CharTab;
      apl_pkg::CharR: esc_c = apl_pkg::CharCr;
      default:        esc_c = c;
    endcase
  end

  // One step of the lexer: next state and up to three results
  always_comb begin
    mode    = state_i.mode;
    wo      = state_i.word_open;
    n       = 2'd0;
    res     = '0;
    do_norm = 1'b0;

    if (in_i.end_of_text) begin
      case (state_i.mode)
        apl_pkg::ModeQuote, apl_pkg::ModeEsc: begin
          res[n] = mk_res(apl_pkg::KindError, 8'd0, 1'b0);
          n = n + 2'd1;
        end
        apl_pkg::ModeSlash: begin
          res[n] = mk_res(apl_pkg::KindWordByte, apl_pkg::CharSlash, !wo);
          n = n + 2'd1;
          res[n] = mk_res(apl_pkg::KindWordEnd, 8'd0, 1'b0);
          n = n + 2'd1;
          res[n] = mk_res(apl_pkg::KindEof, 8'd0, 1'b0);
          n = n + 2'd1;
        end
        apl_pkg::ModeLine, apl_pkg::ModeBlock, apl_pkg::ModeStar: begin
          res[n] = mk_res(apl_pkg::KindEof, 8'd0, 1'b0);
          n = n + 2'd1;
        end
        default: begin
          if (wo) begin
            res[n] = mk_res(apl_pkg::KindWordEnd, 8'd0, 1'b0);
            n = n + 2'd1;
          end
          res[n] = mk_res(apl_pkg::KindEof, 8'd0, 1'b0);
          n = n + 2'd1;
        end
      endcase
      mode = apl_pkg::ModeNormal;
      wo   = 1'b0;
    end else begin
      case (state_i.mode)
        apl_pkg::ModeSlash: begin
          if (c == apl_pkg::CharSlash || c == apl_pkg::CharStar) begin
            if (wo) begin
              res[n] = mk_res(apl_pkg::KindWordEnd, 8'd0, 1'b0);
              n = n + 2'd1;
            end
            wo   = 1'b0;
            mode = (c == apl_pkg::CharSlash) ? apl_pkg::ModeLine : apl_pkg::ModeBlock;
          end else begin
            // lone slash is a word byte, then the byte is lexed as usual
            res[n] = mk_res(apl_pkg::KindWordByte, apl_pkg::CharSlash, !wo);
            n = n + 2'd1;
            wo      = 1'b1;
            do_norm = 1'b1;
          end
        end
        apl_pkg::ModeLine: begin
          if (c == apl_pkg::CharLf) mode = apl_pkg::ModeNormal;
        end
        apl_pkg::ModeBlock: begin
          if (c == apl_pkg::CharStar) mode = apl_pkg::ModeStar;
        end
        apl_pkg::ModeStar: begin
          if (c == apl_pkg::CharSlash) mode = apl_pkg::ModeNormal;
          else if (c != apl_pkg::CharStar) mode = apl_pkg::ModeBlock;
        end
        apl_pkg::ModeQuote: begin
          if (c == apl_pkg::CharQuote) begin
            res[n] = mk_res(apl_pkg::KindWordEnd, 8'd0, 1'b0);
            n = n + 2'd1;
            wo   = 1'b0;
            mode = apl_pkg::ModeNormal;
          end else if (c == apl_pkg::CharBackslash) begin
            mode = apl_pkg::ModeEsc;
          end else begin
            res[n] = mk_res(apl_pkg::KindWordByte, c, !wo);
            n = n + 2'd1;
            wo = 1'b1;
          end
        end
        apl_pkg::ModeEsc: begin
          res[n] = mk_res(apl_pkg::KindWordByte, esc_c, !wo);
          n = n + 2'd1;
          wo   = 1'b1;
          mode = apl_pkg::ModeQuote;
        end
        default: do_norm = 1'b1;
      endcase

      // between tokens or inside an unquoted word
      if (do_norm) begin
        mode = apl_pkg::ModeNormal;
        if (is_space || is_punct) begin
          if (wo) begin
            res[n] = mk_res(apl_pkg::KindWordEnd, 8'd0, 1'b0);
            n = n + 2'd1;
          end
          wo = 1'b0;
          if (is_punct) begin
            res[n] = mk_res(punct_kind, 8'd0, 1'b0);
            n = n + 2'd1;
          end
        end else if (c == apl_pkg::CharSlash) begin
          mode = apl_pkg::ModeSlash;
        end else if (c == apl_pkg::CharQuote && !wo) begin
          mode = apl_pkg::ModeQuote;
        end else begin
          res[n] = mk_res(apl_pkg::KindWordByte, c, !wo);
          n = n + 2'd1;
          wo = 1'b1;
        end
      end
    end

    // mark the last result of this beat
    if (n != 2'd0) res[n - 2'd1].run_last = 1'b1;
  end

  assign state_o.mode      = mode;
  assign state_o.word_open = wo;
  assign res_o             = res;
  assign count_o           = n;

endmodule

>>> design/ascii_plist_lexer_core.sv
// Channel  Direction  Payload        Beat taken when
// in       input      apl_pkg::in_t  in_valid_i  && !in_stall_o
// out      output     apl_pkg::out_t out_valid_o && !out_stall_i
//
// An input beat is registered, lexed once the queue has room, and its zero
// to three results go into a result queue; one leaves per cycle unless stalled.
// Throughput is one input beat per cycle while results drain as fast as they
// are made; the single output port sets the rate at one result per cycle.
// The input stalls only while the queue lacks room for three more results.
// Reset returns the lexer to between-tokens with no open word and empties
// the queue.
module ascii_plist_lexer_core #(
  parameter int unsigned FifoDepthLog2 = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  apl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output apl_pkg::out_t out_data_o
);

  localparam int unsigned FifoDepth = 1 << FifoDepthLog2;
  localparam int unsigned PtrW      = FifoDepthLog2;
  localparam int unsigned CntW      = FifoDepthLog2 + 1;

  // Input register
  logic                in_valid_q;
  apl_pkg::in_t        in_q;

  // Lexer state
  apl_pkg::lex_state_t state_q;
  apl_pkg::lex_state_t state_d;

  // Result queue
  apl_pkg::out_t       fifo_q [FifoDepth];
  logic [PtrW-1:0]     wr_ptr_q;
  logic [PtrW-1:0]     rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic [CntW-1:0]     count_d;
  logic [CntW-1:0]     free_slots;

  apl_pkg::out_t [2:0] step_res;
  logic [1:0]          step_n;
  logic                pop;
  logic                room;
  logic                proc_beat;
  logic                accept;

  apl_step u_step (
    .state_i (state_q),
    .in_i    (in_q),
    .state_o (state_d),
    .res_o   (step_res),
    .count_o (step_n)
  );

  // Flow control
  assign pop        = out_valid_o && !out_stall_i;
  assign free_slots = CntW'(FifoDepth) - count_q + CntW'(pop);
  assign room       = free_slots >= CntW'(apl_pkg::MaxResults);
  assign proc_beat  = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign count_d    = count_q + CntW'(proc_beat ? step_n : 2'd0) - CntW'(pop);

  // Input register and lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      state_q.mode      <= apl_pkg::ModeNormal;
      state_q.word_open <= 1'b0;
    end else begin
      if (accept) in_valid_q <= 1'b1;
      else if (proc_beat) in_valid_q <= 1'b0;
      if (proc_beat) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (proc_beat) wr_ptr_q <= wr_ptr_q + PtrW'(step_n);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (proc_beat && (k < int'(step_n))) begin
        fifo_q[wr_ptr_q + PtrW'(k)] <= step_res[k];
      end
    end
  end

  assign out_valid_o = count_q != '0;
  assign out_data_o  = fifo_q[rd_ptr_q];

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(FifoDepth))
    else $error("result queue overfilled");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + CntW'($past(proc_beat) ? $past(step_n) : 2'd0)
             - CntW'($past(pop)))
    else $error("result queue count mismatch");

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_eot_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_beat && in_q.end_of_text) |=>
      (state_q.mode == apl_pkg::ModeNormal) && !state_q.word_open)
    else $error("lexer state not cleared after end of text");

endmodule
